// ===== hdl/kbhf_pkg.sv =====
package kbhf_pkg;

	// Fixed report layout: modifier byte plus six key slots
	localparam int REPORT_KEYS = 6;
	localparam int KEY_SLOTS   = 6;  // slots that take part in the hotkey test
	localparam int NUM_TARGETS = 4;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	localparam logic [2:0] FUNC_REPORT  = 3'd0;
	localparam logic [2:0] FUNC_TICK    = 3'd1;
	localparam logic [2:0] FUNC_POP     = 3'd2;
	localparam logic [2:0] FUNC_MOUNT   = 3'd3;
	localparam logic [2:0] FUNC_UNMOUNT = 3'd4;

	localparam logic [7:0] REG_PULSE_TICKS = 8'd0;
	localparam logic [7:0] REG_FIRST_KEY   = 8'd1;
	localparam logic [7:0] REG_CTRL_MASK   = 8'd2;
	localparam logic [7:0] REG_ALT_MASK    = 8'd3;

	localparam logic [15:0] PULSE_TICKS_RST = 16'd150;
	localparam logic [7:0]  FIRST_KEY_RST   = 8'd30;
	localparam logic [7:0]  CTRL_MASK_RST   = 8'd17;
	localparam logic [7:0]  ALT_MASK_RST    = 8'd68;

	typedef struct packed {
		logic [7:0]                  modifier;
		logic [REPORT_KEYS-1:0][7:0] keys;
	} report_t;

	// Item after classification in the front
	typedef struct packed {
		logic [2:0] func;
		report_t    rep;
		logic       ctrl;
		logic       alt;
		logic [2:0] tgt;  // 0 none, else one-based target
	} cls_item_t;

	typedef struct packed {
		logic       valid;
		report_t    rep;
		logic [3:0] sel;
		logic       dropped;
	} res_t;

endpackage

// ===== hdl/kbhf_queue.sv =====
module kbhf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		wrap_inc = (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wrap_inc(wr_q);
			if (do_pop) rd_q <= wrap_inc(rd_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

// ===== hdl/kbhf_front.sv =====
module kbhf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [2:0]            func,
	input  kbhf_pkg::report_t     rep_in,
	input  logic [7:0]            first_target_key,
	input  logic [7:0]            ctrl_mask,
	input  logic [7:0]            alt_mask,
	input  logic                  take,
	output logic                  avail,
	output kbhf_pkg::cls_item_t   item
);

	kbhf_pkg::cls_item_t                    cls;
	logic [kbhf_pkg::NUM_TARGETS-1:0]       hit;
	logic [7:0]                             code;
	logic [$bits(kbhf_pkg::cls_item_t)-1:0] q_rdata;
	logic                                   q_empty;

	always_comb begin
		cls          = '0;
		cls.func     = func;
		cls.rep.modifier = rep_in.modifier;
		for (int i = 0; i < kbhf_pkg::KEY_SLOTS; i++) begin
			cls.rep.keys[i] = rep_in.keys[i];
		end
		cls.ctrl = |(rep_in.modifier & ctrl_mask);
		cls.alt  = |(rep_in.modifier & alt_mask);

		// target codes wrap modulo 256
		for (int t = 0; t < kbhf_pkg::NUM_TARGETS; t++) begin
			code   = first_target_key + 8'(t);
			hit[t] = 1'b0;
			for (int i = 0; i < kbhf_pkg::KEY_SLOTS; i++) begin
				if (rep_in.keys[i] == code) hit[t] = 1'b1;
			end
		end

		// lowest target number wins
		priority if (hit[0]) cls.tgt = 3'd1;
		else if (hit[1]) cls.tgt = 3'd2;
		else if (hit[2]) cls.tgt = 3'd3;
		else if (hit[3]) cls.tgt = 3'd4;
		else cls.tgt = 3'd0;
	end

	kbhf_queue #(
		.WIDTH ($bits(kbhf_pkg::cls_item_t)),
		.DEPTH (kbhf_pkg::MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (take),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  ()
	);

	assign avail = ~q_empty;
	assign item  = kbhf_pkg::cls_item_t'(q_rdata);

endmodule

// ===== hdl/kbhf_back.sv =====
module kbhf_back #(
	parameter int FIFO_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  kbhf_pkg::cls_item_t item,
	input  logic [15:0]         pulse_ticks,
	output logic                res_v,
	output kbhf_pkg::res_t      res
);

	localparam int PW = $clog2(FIFO_DEPTH);

	logic [$bits(kbhf_pkg::report_t)-1:0] mem [FIFO_DEPTH];
	logic [$bits(kbhf_pkg::report_t)-1:0] rdata_q;

	logic [PW-1:0] wr_q, rd_q, wr_d, rd_d, push_at, nxt;
	logic          held_q, held_d;
	logic [2:0]    pend_q, pend_d, act_q, act_d;
	logic [15:0]   cnt_q, cnt_d;

	logic              push_en, we, pop_ok, drop;
	kbhf_pkg::report_t push_data;
	logic [3:0]        sel;

	logic       v_s1, pop_ok_s1, drop_s1;
	logic [3:0] sel_s1;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == PW'(FIFO_DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		wr_d      = wr_q;
		rd_d      = rd_q;
		held_d    = held_q;
		pend_d    = pend_q;
		act_d     = act_q;
		cnt_d     = cnt_q;
		push_en   = 1'b0;
		push_at   = wr_q;
		push_data = '0;
		pop_ok    = 1'b0;
		if (fire) begin
			unique case (item.func)
				kbhf_pkg::FUNC_REPORT: begin
					push_en = 1'b1;
					if (!held_q && item.ctrl && item.alt && item.tgt != 3'd0) begin
						held_d = 1'b1;
						if (pend_q == 3'd0) pend_d = item.tgt;
					end else if (held_q) begin
						if (!item.ctrl && !item.alt && item.tgt == 3'd0) held_d = 1'b0;
					end else begin
						push_data = item.rep;
					end
				end
				kbhf_pkg::FUNC_TICK: begin
					if (act_q != 3'd0) begin
						if (cnt_q <= 16'd1) begin
							act_d = 3'd0;
							cnt_d = '0;
						end else begin
							cnt_d = cnt_q - 16'd1;
						end
					end else begin
						if (pend_q != 3'd0) begin
							act_d = pend_q;
							cnt_d = pulse_ticks;
						end
						pend_d = 3'd0;
					end
				end
				kbhf_pkg::FUNC_POP: begin
					if (rd_q != wr_q) begin
						pop_ok = 1'b1;
						rd_d   = ring_next(rd_q);
					end
				end
				kbhf_pkg::FUNC_MOUNT: begin
					rd_d    = '0;
					wr_d    = '0;
					push_at = '0;
					push_en = 1'b1;
				end
				kbhf_pkg::FUNC_UNMOUNT: begin
					rd_d = '0;
					wr_d = '0;
				end
				default: ;
			endcase
		end

		// one slot stays free: full when the next write slot is the read slot
		nxt  = ring_next(push_at);
		drop = push_en && (nxt == rd_d);
		we   = push_en && !drop;
		if (we) wr_d = nxt;

		unique case (act_d)
			3'd1:    sel = 4'b0001;
			3'd2:    sel = 4'b0010;
			3'd3:    sel = 4'b0100;
			3'd4:    sel = 4'b1000;
			default: sel = 4'b0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			held_q <= 1'b0;
			pend_q <= 3'd0;
			act_q  <= 3'd0;
			cnt_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			wr_q   <= wr_d;
			rd_q   <= rd_d;
			held_q <= held_d;
			pend_q <= pend_d;
			act_q  <= act_d;
			cnt_q  <= cnt_d;
			v_s1   <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[push_at] <= push_data;
		// read slot is the pop address whenever a pop executes
		rdata_q   <= mem[rd_q];
		pop_ok_s1 <= pop_ok;
		drop_s1   <= drop;
		sel_s1    <= sel;
	end

	always_comb begin
		res_v       = v_s1;
		res.valid   = pop_ok_s1;
		res.rep     = pop_ok_s1 ? kbhf_pkg::report_t'(rdata_q) : '0;
		res.sel     = sel_s1;
		res.dropped = drop_s1;
	end

endmodule

// ===== hdl/keyboard_hotkey_filter_queue_unit.sv =====
// Keyboard hotkey filter with report queue. Events (report, tick, pop, host mount,
// host unmount) go in through push/full and each gives exactly one result through
// empty/pop, in order. One event per clock is taken sustained while results are
// popped as fast and no queue is full; a result passes the classify queue, the
// execute stage, whose report store read is registered, and the result queue. A four-entry
// classify queue and a four-entry result queue let each side stall on its own.
// The report store is a FIFO_DEPTH-entry memory with one slot kept free. Configuration
// registers: 0 pulse_ticks, 1 first_target_key, 2 ctrl_mask, 3 alt_mask; writes
// to other indexes are ignored and cfg_ready is always high.
module keyboard_hotkey_filter_queue_unit #(
	parameter int FIFO_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  func,
	input  logic [7:0]  in_modifier,
	input  logic [7:0]  in_key_0,
	input  logic [7:0]  in_key_1,
	input  logic [7:0]  in_key_2,
	input  logic [7:0]  in_key_3,
	input  logic [7:0]  in_key_4,
	input  logic [7:0]  in_key_5,
	output logic        empty,
	input  logic        pop,
	output logic        out_valid,
	output logic [7:0]  out_modifier,
	output logic [7:0]  out_key_0,
	output logic [7:0]  out_key_1,
	output logic [7:0]  out_key_2,
	output logic [7:0]  out_key_3,
	output logic [7:0]  out_key_4,
	output logic [7:0]  out_key_5,
	output logic [3:0]  select_lines,
	output logic        dropped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int OCW = $clog2(kbhf_pkg::OUT_DEPTH + 1);

	logic [15:0] pulse_ticks_q;
	logic [7:0]  first_key_q, ctrl_mask_q, alt_mask_q;

	kbhf_pkg::report_t   rep_in;
	kbhf_pkg::cls_item_t item;
	kbhf_pkg::res_t      res, out_res;
	logic                avail, fire, res_v, out_full;
	logic [OCW-1:0]      out_count;
	logic [$bits(kbhf_pkg::res_t)-1:0] out_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q <= kbhf_pkg::PULSE_TICKS_RST;
			first_key_q   <= kbhf_pkg::FIRST_KEY_RST;
			ctrl_mask_q   <= kbhf_pkg::CTRL_MASK_RST;
			alt_mask_q    <= kbhf_pkg::ALT_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kbhf_pkg::REG_PULSE_TICKS: pulse_ticks_q <= cfg_data;
				kbhf_pkg::REG_FIRST_KEY:   first_key_q   <= cfg_data[7:0];
				kbhf_pkg::REG_CTRL_MASK:   ctrl_mask_q   <= cfg_data[7:0];
				kbhf_pkg::REG_ALT_MASK:    alt_mask_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rep_in.modifier = in_modifier;
		rep_in.keys[0]  = in_key_0;
		rep_in.keys[1]  = in_key_1;
		rep_in.keys[2]  = in_key_2;
		rep_in.keys[3]  = in_key_3;
		rep_in.keys[4]  = in_key_4;
		rep_in.keys[5]  = in_key_5;
	end

	kbhf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.func             (func),
		.rep_in           (rep_in),
		.first_target_key (first_key_q),
		.ctrl_mask        (ctrl_mask_q),
		.alt_mask         (alt_mask_q),
		.take             (fire),
		.avail            (avail),
		.item             (item)
	);

	// execute only with a guaranteed slot for the result, counting the one in flight
	assign fire = avail && ((out_count + OCW'(res_v)) < OCW'(kbhf_pkg::OUT_DEPTH));

	kbhf_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item),
		.pulse_ticks (pulse_ticks_q),
		.res_v       (res_v),
		.res         (res)
	);

	kbhf_queue #(
		.WIDTH ($bits(kbhf_pkg::res_t)),
		.DEPTH (kbhf_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_v),
		.wdata  (res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty),
		.count  (out_count)
	);

	assign out_res      = kbhf_pkg::res_t'(out_rdata);
	assign out_valid    = out_res.valid;
	assign out_modifier = out_res.rep.modifier;
	assign out_key_0    = out_res.rep.keys[0];
	assign out_key_1    = out_res.rep.keys[1];
	assign out_key_2    = out_res.rep.keys[2];
	assign out_key_3    = out_res.rep.keys[3];
	assign out_key_4    = out_res.rep.keys[4];
	assign out_key_5    = out_res.rep.keys[5];
	assign select_lines = out_res.sel;
	assign dropped      = out_res.dropped;

	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |-> !out_full)
		else $error("result transfer into a full result queue");

	a_select_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot0(select_lines))
		else $error("more than one select line active");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_valid) |-> (out_modifier == 8'd0 && out_key_0 == 8'd0 &&
			out_key_1 == 8'd0 && out_key_2 == 8'd0 && out_key_3 == 8'd0 &&
			out_key_4 == 8'd0 && out_key_5 == 8'd0))
		else $error("report fields set without a popped report");

	a_fire_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_v)
		else $error("executed event gave no result");

endmodule

// ===== verif/tb_keyboard_hotkey_filter_queue_unit.sv =====
module tb_keyboard_hotkey_filter_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH    = 32;
	localparam int PHASE_EVENTS  = 200;
	localparam int NUM_PHASES    = 6;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 16;

	// func codes with no action
	localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
	localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
	localparam logic [2:0] FUNC_RSVD_7 = 3'd7;
	localparam logic [7:0] REG_INDEX_MAX = 8'hFF;

	localparam kbhf_pkg::res_t NO_RESULT = '0;

	typedef struct packed {
		logic [2:0]        f;
		kbhf_pkg::report_t rep;
		logic              typed;
		kbhf_pkg::res_t    want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  func;
	logic [7:0]  in_modifier;
	logic [7:0]  in_key_0, in_key_1, in_key_2, in_key_3, in_key_4, in_key_5;
	logic        empty;
	logic        pop;
	logic        out_valid;
	logic [7:0]  out_modifier;
	logic [7:0]  out_key_0, out_key_1, out_key_2, out_key_3, out_key_4, out_key_5;
	logic [3:0]  select_lines;
	logic        dropped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	keyboard_hotkey_filter_queue_unit #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.in_modifier(in_modifier),
		.in_key_0(in_key_0),
		.in_key_1(in_key_1),
		.in_key_2(in_key_2),
		.in_key_3(in_key_3),
		.in_key_4(in_key_4),
		.in_key_5(in_key_5),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_modifier(out_modifier),
		.out_key_0(out_key_0),
		.out_key_1(out_key_1),
		.out_key_2(out_key_2),
		.out_key_3(out_key_3),
		.out_key_4(out_key_4),
		.out_key_5(out_key_5),
		.select_lines(select_lines),
		.dropped(dropped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the filter state and registers
	kbhf_pkg::report_t mirror_store [FIFO_DEPTH];
	int          mirror_wr;
	int          mirror_rd;
	bit          mirror_latched;
	logic [2:0]  mirror_pending;
	logic [2:0]  mirror_active;
	logic [15:0] mirror_countdown;
	logic [15:0] reg_pulse_ticks;
	logic [7:0]  reg_first_key;
	logic [7:0]  reg_ctrl_mask;
	logic [7:0]  reg_alt_mask;

	kbhf_pkg::res_t awaited_results [$];
	dir_row_t       directed_rows [$];

	int tx_idle;
	int rx_idle;
	int mismatches;
	int events_sent;
	int results_seen;
	int latch_count;
	int pulse_count;
	int drop_count;

	function automatic bit store_report(kbhf_pkg::report_t r);
		int nxt;
		nxt = (mirror_wr + 1) % FIFO_DEPTH;
		if (nxt == mirror_rd)
			return 1'b1;
		mirror_store[mirror_wr] = r;
		mirror_wr = nxt;
		return 1'b0;
	endfunction

	// lowest target number present, zero when none
	function automatic logic [2:0] target_of(kbhf_pkg::report_t r);
		logic [7:0] code;
		for (int t = 0; t < kbhf_pkg::NUM_TARGETS; t++) begin
			code = reg_first_key + 8'(t);
			for (int i = 0; i < kbhf_pkg::KEY_SLOTS; i++)
				if (r.keys[i] == code)
					return 3'(t + 1);
		end
		return 3'd0;
	endfunction

	function automatic kbhf_pkg::res_t filter_event(logic [2:0] f, kbhf_pkg::report_t r);
		kbhf_pkg::res_t    res;
		kbhf_pkg::report_t released;
		logic       is_ctrl;
		logic       is_alt;
		logic [2:0] tgt;
		res = '0;
		released = '0;
		for (int i = kbhf_pkg::KEY_SLOTS; i < kbhf_pkg::REPORT_KEYS; i++)
			r.keys[i] = 8'h00;
		case (f)
			kbhf_pkg::FUNC_REPORT: begin
				is_ctrl = |(r.modifier & reg_ctrl_mask);
				is_alt = |(r.modifier & reg_alt_mask);
				tgt = target_of(r);
				if (!mirror_latched && is_ctrl && is_alt && tgt != 3'd0) begin
					res.dropped = store_report(released);
					if (mirror_pending == 3'd0)
						mirror_pending = tgt;
					mirror_latched = 1'b1;
					latch_count++;
				end else if (mirror_latched) begin
					if (!is_ctrl && !is_alt && tgt == 3'd0)
						mirror_latched = 1'b0;
					res.dropped = store_report(released);
				end else begin
					res.dropped = store_report(r);
				end
			end
			kbhf_pkg::FUNC_TICK: begin
				if (mirror_active != 3'd0) begin
					if (mirror_countdown <= 16'd1) begin
						mirror_active = 3'd0;
						mirror_countdown = 16'd0;
					end else begin
						mirror_countdown = mirror_countdown - 16'd1;
					end
				end else begin
					if (mirror_pending >= 3'd1 &&
							mirror_pending <= 3'(kbhf_pkg::NUM_TARGETS)) begin
						mirror_active = mirror_pending;
						mirror_countdown = reg_pulse_ticks;
						pulse_count++;
					end
					mirror_pending = 3'd0;
				end
			end
			kbhf_pkg::FUNC_POP: begin
				if (mirror_rd != mirror_wr) begin
					res.rep = mirror_store[mirror_rd];
					mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
					res.valid = 1'b1;
				end
			end
			kbhf_pkg::FUNC_MOUNT: begin
				mirror_wr = 0;
				mirror_rd = 0;
				res.dropped = store_report(released);
			end
			kbhf_pkg::FUNC_UNMOUNT: begin
				mirror_wr = 0;
				mirror_rd = 0;
			end
			default: ;
		endcase
		if (mirror_active >= 3'd1 && mirror_active <= 3'(kbhf_pkg::NUM_TARGETS))
			res.sel = 4'(1 << (mirror_active - 3'd1));
		if (res.dropped)
			drop_count++;
		return res;
	endfunction

	function automatic logic [7:0] one_bit_of(logic [7:0] m);
		int b;
		if (m == 8'h00)
			return 8'h00;
		b = $urandom_range(7);
		while (!m[b])
			b = (b + 1) % 8;
		return 8'(1 << b);
	endfunction

	// chord presses, releases and noise, shaped by the current masks and targets
	function automatic kbhf_pkg::report_t make_report();
		kbhf_pkg::report_t r;
		int         kind;
		logic [7:0] both;
		r.modifier = 8'($urandom);
		for (int i = 0; i < kbhf_pkg::REPORT_KEYS; i++)
			r.keys[i] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
		both = reg_ctrl_mask | reg_alt_mask;
		kind = $urandom_range(99);
		if (kind < 30) begin
			r.modifier = one_bit_of(reg_ctrl_mask) | one_bit_of(reg_alt_mask) |
				(($urandom_range(1) == 1) ? r.modifier : 8'h00);
			r.keys[$urandom_range(kbhf_pkg::KEY_SLOTS - 1)] =
				reg_first_key + 8'($urandom_range(kbhf_pkg::NUM_TARGETS - 1));
		end else if (kind < 60) begin
			r.modifier = r.modifier & ~both;
			for (int i = 0; i < kbhf_pkg::REPORT_KEYS; i++)
				if (8'(r.keys[i] - reg_first_key) < 8'(kbhf_pkg::NUM_TARGETS))
					r.keys[i] = reg_first_key + 8'(kbhf_pkg::NUM_TARGETS);
		end
		return r;
	endfunction

	function automatic dir_row_t row(logic [2:0] f, logic [7:0] m, logic [47:0] k,
			logic typed, kbhf_pkg::res_t want);
		dir_row_t d;
		d.f = f;
		d.rep = {m, k};
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] result %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic check_result();
		kbhf_pkg::res_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("result with no event waiting");
			return;
		end
		want = awaited_results.pop_front();
		check_field("out_valid", {7'd0, out_valid}, {7'd0, want.valid});
		check_field("out_modifier", out_modifier, want.rep.modifier);
		check_field("out_key_0", out_key_0, want.rep.keys[0]);
		check_field("out_key_1", out_key_1, want.rep.keys[1]);
		check_field("out_key_2", out_key_2, want.rep.keys[2]);
		check_field("out_key_3", out_key_3, want.rep.keys[3]);
		check_field("out_key_4", out_key_4, want.rep.keys[4]);
		check_field("out_key_5", out_key_5, want.rep.keys[5]);
		check_field("select_lines", {4'd0, select_lines}, {4'd0, want.sel});
		check_field("dropped", {7'd0, dropped}, {7'd0, want.dropped});
	endtask

	task automatic send_event(logic [2:0] f, kbhf_pkg::report_t r, logic typed,
			kbhf_pkg::res_t want);
		kbhf_pkg::res_t predicted;
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		in_modifier <= r.modifier;
		in_key_0 <= r.keys[0];
		in_key_1 <= r.keys[1];
		in_key_2 <= r.keys[2];
		in_key_3 <= r.keys[3];
		in_key_4 <= r.keys[4];
		in_key_5 <= r.keys[5];
		@(posedge clk);
		while (full)
			@(posedge clk);
		predicted = filter_event(f, r);
		awaited_results.push_back(typed ? want : predicted);
		events_sent++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			kbhf_pkg::REG_PULSE_TICKS: reg_pulse_ticks = data;
			kbhf_pkg::REG_FIRST_KEY:   reg_first_key = data[7:0];
			kbhf_pkg::REG_CTRL_MASK:   reg_ctrl_mask = data[7:0];
			kbhf_pkg::REG_ALT_MASK:    reg_alt_mask = data[7:0];
			default: ;
		endcase
	endtask

	// upper byte of the 8-bit registers carries noise
	task automatic program_regs(logic [15:0] pulse, logic [7:0] first, logic [7:0] ctrl,
			logic [7:0] alt, logic [7:0] stray_idx);
		write_reg(kbhf_pkg::REG_PULSE_TICKS, pulse);
		write_reg(kbhf_pkg::REG_FIRST_KEY, {8'($urandom), first});
		write_reg(kbhf_pkg::REG_CTRL_MASK, {8'($urandom), ctrl});
		write_reg(kbhf_pkg::REG_ALT_MASK, {8'($urandom), alt});
		write_reg(stray_idx, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side
	initial begin
		pop <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_result();
				results_seen++;
			end
			pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [2:0] f;
		kbhf_pkg::report_t r;
		int         n;
		int         step;
		int         pop_pct;
		int         pick;

		arst_n <= 1'b0;
		push <= 1'b0;
		func <= kbhf_pkg::FUNC_REPORT;
		in_modifier <= 8'h00;
		in_key_0 <= 8'h00;
		in_key_1 <= 8'h00;
		in_key_2 <= 8'h00;
		in_key_3 <= 8'h00;
		in_key_4 <= 8'h00;
		in_key_5 <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= kbhf_pkg::REG_PULSE_TICKS;
		cfg_data <= 16'h0000;
		tx_idle = 0;
		rx_idle = 0;
		mismatches = 0;
		events_sent = 0;
		results_seen = 0;
		latch_count = 0;
		pulse_count = 0;
		drop_count = 0;
		mirror_wr = 0;
		mirror_rd = 0;
		mirror_latched = 1'b0;
		mirror_pending = 3'd0;
		mirror_active = 3'd0;
		mirror_countdown = 16'd0;
		reg_pulse_ticks = kbhf_pkg::PULSE_TICKS_RST;
		reg_first_key = kbhf_pkg::FIRST_KEY_RST;
		reg_ctrl_mask = kbhf_pkg::CTRL_MASK_RST;
		reg_alt_mask = kbhf_pkg::ALT_MASK_RST;

		// reset values: targets 0x1e..0x21, ctrl bits 0/4, alt bits 2/6
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b1, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_TICK, 8'h00, 48'h0, 1'b1, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b1,
			{1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 4'd0, 1'b0}));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h00, 48'h0, 1'b1, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1,
			{1'b1, 56'd0, 4'd0, 1'b0}));
		// two targets in one chord, lower one wins
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h05, 48'h0000_0000_1F21, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h11, 48'h0000_0000_001E, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_TICK, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h44, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h00, 48'h0000_0000_0004, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h01, 48'h0000_0000_001E, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'h50, 48'h2100_0000_0000, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_TICK, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_MOUNT, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_REPORT, 8'hAA, 48'h0102_0304_0506, 1'b0,
			NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_UNMOUNT, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(kbhf_pkg::FUNC_POP, 8'h00, 48'h0, 1'b0, NO_RESULT));
		directed_rows.push_back(row(FUNC_RSVD_5, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RESULT));
		directed_rows.push_back(row(FUNC_RSVD_6, 8'h55, 48'hAAAA_AAAA_AAAA, 1'b0, NO_RESULT));
		directed_rows.push_back(row(FUNC_RSVD_7, 8'hAA, 48'h5555_5555_5555, 1'b0, NO_RESULT));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_event(directed_rows[i].f, directed_rows[i].rep, directed_rows[i].typed,
				directed_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			case (p)
				0: begin
					tx_idle = 9;
					rx_idle = 85;
					program_regs(16'd1, 8'd0, 8'hFF, 8'hFF, REG_INDEX_MAX);
				end
				1: begin
					tx_idle = 9;
					rx_idle = 85;
					program_regs(16'd3, 8'hFF, 8'h01, 8'h80,
						8'($urandom_range(kbhf_pkg::REG_ALT_MASK + 1, REG_INDEX_MAX)));
				end
				2: begin
					tx_idle = 85;
					rx_idle = 9;
					// zero length acts as a single tick
					program_regs(16'd0, 8'd253, 8'h11, 8'h44,
						8'($urandom_range(kbhf_pkg::REG_ALT_MASK + 1, REG_INDEX_MAX)));
				end
				3: begin
					tx_idle = 85;
					rx_idle = 9;
					// no ctrl bits: no chord can latch
					program_regs(16'($urandom_range(1, 8)), 8'($urandom), 8'h00, 8'hFF,
						8'($urandom_range(kbhf_pkg::REG_ALT_MASK + 1, REG_INDEX_MAX)));
				end
				4: begin
					tx_idle = 0;
					rx_idle = 0;
					program_regs(16'd2, kbhf_pkg::FIRST_KEY_RST, 8'h0F, 8'hF0,
						8'($urandom_range(kbhf_pkg::REG_ALT_MASK + 1, REG_INDEX_MAX)));
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
					program_regs(16'hFFFF, 8'($urandom), 8'($urandom_range(1, 255)),
						8'($urandom_range(1, 255)),
						8'($urandom_range(kbhf_pkg::REG_ALT_MASK + 1, REG_INDEX_MAX)));
				end
			endcase

			n = 0;
			step = 0;
			pop_pct = 20;
			while (n < PHASE_EVENTS) begin
				// pop rate swings so the store both fills up and runs dry
				if (step % 50 == 0) begin
					pick = $urandom_range(2);
					pop_pct = (pick == 0) ? 4 : (pick == 1) ? 20 : 35;
				end
				if (step == 100)
					drain_results();
				pick = $urandom_range(99);
				if (pick < pop_pct)
					f = kbhf_pkg::FUNC_POP;
				else if (pick < pop_pct + 15)
					f = kbhf_pkg::FUNC_TICK;
				else if (pick < pop_pct + 17)
					f = kbhf_pkg::FUNC_MOUNT;
				else if (pick < pop_pct + 19)
					f = kbhf_pkg::FUNC_UNMOUNT;
				else if (pick < pop_pct + 21)
					f = 3'($urandom_range(FUNC_RSVD_5, FUNC_RSVD_7));
				else
					f = kbhf_pkg::FUNC_REPORT;
				if (f == kbhf_pkg::FUNC_REPORT) begin
					r = make_report();
				end else begin
					r.modifier = 8'($urandom);
					for (int i = 0; i < kbhf_pkg::REPORT_KEYS; i++)
						r.keys[i] = 8'($urandom);
				end
				send_event(f, r, 1'b0, NO_RESULT);
				if (f <= kbhf_pkg::FUNC_UNMOUNT)
					n++;
				step++;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d events over %0d register settings, %0d results compared",
			events_sent, NUM_PHASES + 1, results_seen);
		$display("%0d hotkey latches, %0d select pulses, %0d reports dropped on a full store",
			latch_count, pulse_count, drop_count);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== keyboard_hotkey_filter_queue_unit.f =====
hdl/kbhf_pkg.sv
hdl/kbhf_queue.sv
hdl/kbhf_front.sv
hdl/kbhf_back.sv
hdl/keyboard_hotkey_filter_queue_unit.sv
verif/tb_keyboard_hotkey_filter_queue_unit.sv
